// File: design/mp3_wola_pkg.sv
// Shared types, constants, cosine ROM and arithmetic helpers of the IMDCT block.
`default_nettype none

package mp3_wola_pkg;

    localparam int NUM_CHANNELS = 2;
    localparam int NUM_SUBBANDS = 32;
    localparam int LINES        = 18;
    localparam int ROWS         = NUM_CHANNELS * NUM_SUBBANDS;
    localparam int ROW_W        = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam int ADDR_W       = $clog2(ROWS * LINES);
    localparam int ACC_W        = 38;

    localparam logic [1:0] BT_NORMAL = 2'd0;
    localparam logic [1:0] BT_START  = 2'd1;
    localparam logic [1:0] BT_SHORT  = 2'd2;
    localparam logic [1:0] BT_STOP   = 2'd3;

    localparam logic [63:0] DEC_SCALE = 64'd1000000000;

    typedef logic signed [31:0]      q24_t;
    typedef logic signed [ACC_W-1:0] acc_t;
    typedef logic [0:36][63:0]       cos_dec_t;
    typedef logic [0:36][31:0]       cos_rom_t;

    typedef struct packed {
        logic clear;
        logic valid;
    } mac_ctl_t;

    typedef struct packed {
        logic wr_en;
        logic set_valid;
    } ovl_ctl_t;

    // cos(pi*j/72), nine decimals
    localparam cos_dec_t COS_DEC = '{
        64'd1000000000, 64'd999048222, 64'd996194698, 64'd991444861, 64'd984807753,
        64'd976296007,  64'd965925826, 64'd953716951, 64'd939692621, 64'd923879533,
        64'd906307787,  64'd887010833, 64'd866025404, 64'd843391446, 64'd819152044,
        64'd793353340,  64'd766044443, 64'd737277337, 64'd707106781, 64'd675590208,
        64'd642787610,  64'd608761429, 64'd573576436, 64'd537299608, 64'd500000000,
        64'd461748613,  64'd422618262, 64'd382683432, 64'd342020143, 64'd300705800,
        64'd258819045,  64'd216439614, 64'd173648178, 64'd130526192, 64'd87155743,
        64'd43619387,   64'd0
    };

    function automatic cos_rom_t build_cos_rom();
        cos_rom_t    rom;
        logic [63:0] tmp;
        for (int j = 0; j < 37; j++)
        begin
            tmp    = COS_DEC[j] * 64'd1073741824 + 64'd500000000;
            rom[j] = 32'(tmp / DEC_SCALE);
        end
        return rom;
    endfunction

    // Q1.30 cosine ROM
    localparam cos_rom_t COS_ROM = build_cos_rom();

    function automatic q24_t sat32(input logic signed [39:0] x);
        if (x > 40'sd2147483647)
            return 32'sh7FFFFFFF;
        else if (x < -40'sd2147483648)
            return 32'sh80000000;
        else
            return x[31:0];
    endfunction

    function automatic logic signed [33:0] round_q30(input logic signed [63:0] p);
        logic signed [63:0] tmp;
        tmp = p + 64'sd536870912;
        return $signed(tmp[63:30]);
    endfunction

    // cos(pi*m/72) for m in 0..143, folded onto the quarter-wave ROM
    function automatic q24_t cos_q30(input logic [7:0] m);
        logic [7:0]  r;
        logic        neg;
        logic [5:0]  idx;
        q24_t        v;
        r   = (m > 8'd72) ? 8'd144 - m : m;
        neg = (r > 8'd36);
        idx = neg ? 6'(8'd72 - r) : 6'(r);
        v   = $signed(COS_ROM[idx]);
        return neg ? -v : v;
    endfunction

endpackage

`default_nettype wire

// File: design/mp3_wola_cell.sv
// One line cell of the rotating coefficient ring.
`default_nettype none

module mp3_wola_cell (
    input  logic               clk,
    input  logic               load_en,
    input  mp3_wola_pkg::q24_t load_data,
    input  logic               shift_en,
    input  mp3_wola_pkg::q24_t shift_in,
    output mp3_wola_pkg::q24_t value
);
    import mp3_wola_pkg::*;

    q24_t value_reg;
    q24_t value_next;

    always_comb
    begin
        value_next = value_reg;
        if (load_en)
            value_next = load_data;
        else if (shift_en)
            value_next = shift_in;
    end

    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
    end

    assign value = value_reg;

endmodule

`default_nettype wire

// File: design/mp3_wola_mac.sv
// Pipelined multiply, Q30 round and accumulate unit.
`default_nettype none

module mp3_wola_mac (
    input  logic                   clk,
    input  logic                   rst_n,
    input  mp3_wola_pkg::mac_ctl_t ctl,
    input  mp3_wola_pkg::q24_t     data,
    input  mp3_wola_pkg::q24_t     coef,
    output mp3_wola_pkg::acc_t     acc
);
    import mp3_wola_pkg::*;

    logic               v1_reg;
    logic               v2_reg;
    q24_t               a_reg;
    q24_t               c_reg;
    logic signed [63:0] prod_reg;
    acc_t               acc_reg;
    acc_t               acc_next;

    always_comb
    begin
        acc_next = acc_reg;
        if (ctl.clear)
            acc_next = '0;
        else if (v2_reg)
            acc_next = acc_reg + ACC_W'(round_q30(prod_reg));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= ctl.valid;
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        a_reg    <= data;
        c_reg    <= coef;
        prod_reg <= a_reg * c_reg;
        acc_reg  <= acc_next;
    end

    assign acc = acc_reg;

endmodule

`default_nettype wire

// File: design/mp3_wola_ovl.sv
// Overlap store: one row of 18 samples per channel and subband, with row valid bits.
`default_nettype none

module mp3_wola_ovl (
    input  logic                             clk,
    input  logic                             rst_n,
    input  mp3_wola_pkg::ovl_ctl_t           ctl,
    input  logic [mp3_wola_pkg::ROW_W-1:0]   row,
    input  logic [4:0]                       line,
    input  mp3_wola_pkg::q24_t               wr_data,
    output mp3_wola_pkg::q24_t               rd_data
);
    import mp3_wola_pkg::*;

    q24_t              mem [ROWS*LINES];
    q24_t              rd_reg;
    logic [ROWS-1:0]   valid_reg;
    logic [ROWS-1:0]   valid_next;
    logic [ADDR_W-1:0] addr;

    assign addr = ADDR_W'(32'(row) * LINES + 32'(line));

    always_comb
    begin
        valid_next = valid_reg;
        if (ctl.set_valid)
            valid_next = valid_reg | (ROWS'(1) << row);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= '0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (ctl.wr_en)
            mem[addr] <= wr_data;
        rd_reg <= mem[addr];
    end

    // a row never written reads as zero
    assign rd_data = valid_reg[row] ? rd_reg : '0;

endmodule

`default_nettype wire

// File: design/mp3_imdct_window_overlap_add.sv
// Top level: line ring, IMDCT sequencer, windowing and overlap-add.
`default_nettype none

// Loads the 18 lines of a subband, one item each, into a ring of 18 cells; the
// item with line_index 17 starts the transform, and no item is taken until it
// ends. Each of the 36 frame samples takes one pass of the ring past a single
// multiply-accumulate unit, then drain, window, sum and store; a short block
// runs 36 windowed pieces in all and skips the slots that lie outside its
// window. The 18 output items come out during the first half of the
// transform through a one-entry output register. The overlap store needs no
// clearing pass: each (channel, subband) row carries a valid bit cleared by
// reset and reads as zero until its first transform completes.
module mp3_imdct_window_overlap_add (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [39:0] s_axis_tdata,   // coefficient[31:0], line_index[36:32], zero fill
    input  logic [7:0]  s_axis_tuser,   // channel[0], subband[5:1], window_kind[7:6]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata,   // sample[31:0], sample_index[36:32], zero fill
    output logic        m_axis_tlast
);
    import mp3_wola_pkg::*;

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_SETUP  = 3'd1;
    localparam logic [2:0] ST_RUN    = 3'd2;
    localparam logic [2:0] ST_DRAIN  = 3'd3;
    localparam logic [2:0] ST_WIN    = 3'd4;
    localparam logic [2:0] ST_PIECE  = 3'd5;
    localparam logic [2:0] ST_FINISH = 3'd6;

    localparam q24_t WIN_ONE = 32'sh40000000;

    function automatic q24_t win_normal(input logic [5:0] i);
        logic [6:0] t;
        logic [6:0] a;
        t = {i, 1'b0};
        a = (t < 7'd35) ? 7'd35 - t : t - 7'd35;
        return $signed(COS_ROM[6'(a)]);
    endfunction

    function automatic q24_t win_short(input logic [3:0] i);
        logic [6:0] t;
        logic [6:0] a;
        t = 7'({i, 2'b00}) + 7'({i, 1'b0});
        a = (t < 7'd33) ? 7'd33 - t : t - 7'd33;
        return $signed(COS_ROM[6'(a)]);
    endfunction

    // input fields
    q24_t       coef_in;
    logic [4:0] idx_in;
    logic       ch_in;
    logic [4:0] sb_in;
    logic [1:0] bt_in;
    logic       in_fire;
    logic       in_range;
    logic       start;

    // sequencer
    logic [2:0]       state_reg, state_next;
    logic [5:0]       j_reg, j_next;
    logic [1:0]       w_reg, w_next;
    logic [4:0]       k_reg, k_next;
    logic [2:0]       kk_reg, kk_next;
    logic [1:0]       g_reg, g_next;
    logic [7:0]       m_reg, m_next;
    logic [7:0]       m_start_reg, m_start_next;
    logic [7:0]       m_step_reg, m_step_next;
    q24_t             win_reg, win_next;
    logic [1:0]       bt_reg, bt_next;
    logic [ROW_W-1:0] row_reg, row_next;
    logic signed [63:0] win_prod_reg, win_prod_next;
    logic signed [33:0] frame_reg, frame_next;

    logic       out_valid_reg, out_valid_next;
    q24_t       out_sample_reg, out_sample_next;
    logic [4:0] out_index_reg, out_index_next;
    logic       out_last_reg, out_last_next;

    // slot setup
    logic       is_short;
    logic [5:0] off_w;
    logic       slot_ok;
    logic [5:0] i_s;
    logic [7:0] start_m;
    logic [8:0] step2;
    logic [7:0] step_m;
    q24_t       win_val;
    logic [8:0] sum9;
    logic [7:0] m_adv;

    // datapath links
    q24_t      cell_q [LINES];
    logic      shift_en;
    mac_ctl_t  mac_ctl;
    acc_t      acc;
    q24_t      acc_sat;
    ovl_ctl_t  ovl_ctl;
    logic [4:0] idx18;
    q24_t      ovl_rd;
    q24_t      ovl_wr;
    q24_t      sample_val;
    logic      out_free;

    assign coef_in  = s_axis_tdata[31:0];
    assign idx_in   = s_axis_tdata[36:32];
    assign ch_in    = s_axis_tuser[0];
    assign sb_in    = s_axis_tuser[5:1];
    assign bt_in    = s_axis_tuser[7:6];

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign in_fire       = s_axis_tvalid && s_axis_tready;
    assign in_range      = (32'(ch_in) < NUM_CHANNELS) && (32'(sb_in) < NUM_SUBBANDS);
    assign start         = in_fire && (idx_in == 5'd17) && in_range;

    assign shift_en = (state_reg == ST_RUN);

    genvar gi;
    generate
        for (gi = 0; gi < LINES; gi++)
        begin : g_cell
            mp3_wola_cell u_cell (
                .clk       (clk),
                .load_en   (in_fire && (idx_in == 5'(gi))),
                .load_data (coef_in),
                .shift_en  (shift_en),
                .shift_in  (cell_q[(gi + 1) % LINES]),
                .value     (cell_q[gi])
            );
        end
    endgenerate

    assign is_short = (bt_reg == BT_SHORT);

    always_comb
    begin
        unique case (w_reg)
            2'd0:    off_w = 6'd6;
            2'd1:    off_w = 6'd12;
            default: off_w = 6'd18;
        endcase
    end

    always_comb
    begin
        i_s     = j_reg - off_w;
        slot_ok = !is_short || ((j_reg >= off_w) && (j_reg < off_w + 6'd12));
        if (is_short)
            start_m = 8'({i_s, 2'b00}) + 8'({i_s, 1'b0}) + 8'd21;
        else
            start_m = 8'({j_reg, 1'b0}) + 8'd19;
        step2  = {start_m, 1'b0};
        step_m = (step2 >= 9'd144) ? 8'(step2 - 9'd144) : step2[7:0];
    end

    always_comb
    begin
        if (is_short)
            win_val = win_short(i_s[3:0]);
        else if (bt_reg == BT_START)
        begin
            if (j_reg < 6'd18)
                win_val = win_normal(j_reg);
            else if (j_reg < 6'd24)
                win_val = WIN_ONE;
            else if (j_reg < 6'd30)
                win_val = win_short(4'(j_reg - 6'd18));
            else
                win_val = '0;
        end
        else if (bt_reg == BT_STOP)
        begin
            if (j_reg < 6'd6)
                win_val = '0;
            else if (j_reg < 6'd12)
                win_val = win_short(4'(j_reg - 6'd6));
            else if (j_reg < 6'd18)
                win_val = WIN_ONE;
            else
                win_val = win_normal(j_reg);
        end
        else
            win_val = win_normal(j_reg);
    end

    assign sum9  = {1'b0, m_reg} + {1'b0, m_step_reg};
    assign m_adv = (sum9 >= 9'd144) ? 8'(sum9 - 9'd144) : sum9[7:0];

    assign mac_ctl.clear = (state_reg == ST_SETUP) && slot_ok;
    assign mac_ctl.valid = (state_reg == ST_RUN) && (!is_short || (g_reg == w_reg));

    mp3_wola_mac u_mac (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (mac_ctl),
        .data  (cell_q[0]),
        .coef  (cos_q30(m_reg)),
        .acc   (acc)
    );

    assign acc_sat    = sat32(40'(acc));
    assign idx18      = (j_reg < 6'd18) ? 5'(j_reg) : 5'(j_reg - 6'd18);
    assign ovl_wr     = sat32(40'(frame_reg));
    assign sample_val = sat32(40'(frame_reg) + 40'(ovl_rd));
    assign out_free   = !out_valid_reg || m_axis_tready;

    assign ovl_ctl.wr_en     = (state_reg == ST_FINISH) && (j_reg >= 6'd18);
    assign ovl_ctl.set_valid = (state_reg == ST_FINISH) && (j_reg == 6'd35);

    mp3_wola_ovl u_ovl (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctl     (ovl_ctl),
        .row     (row_reg),
        .line    (idx18),
        .wr_data (ovl_wr),
        .rd_data (ovl_rd)
    );

    always_comb
    begin
        state_next      = state_reg;
        j_next          = j_reg;
        w_next          = w_reg;
        k_next          = k_reg;
        kk_next         = kk_reg;
        g_next          = g_reg;
        m_next          = m_reg;
        m_start_next    = m_start_reg;
        m_step_next     = m_step_reg;
        win_next        = win_reg;
        bt_next         = bt_reg;
        row_next        = row_reg;
        win_prod_next   = win_prod_reg;
        frame_next      = frame_reg;
        out_valid_next  = out_valid_reg && !m_axis_tready;
        out_sample_next = out_sample_reg;
        out_index_next  = out_index_reg;
        out_last_next   = out_last_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    bt_next    = bt_in;
                    row_next   = ROW_W'(32'(ch_in) * NUM_SUBBANDS + 32'(sb_in));
                    j_next     = '0;
                    w_next     = '0;
                    frame_next = '0;
                    state_next = ST_SETUP;
                end
            end
            ST_SETUP:
            begin
                if (slot_ok)
                begin
                    m_next       = start_m;
                    m_start_next = start_m;
                    m_step_next  = step_m;
                    win_next     = win_val;
                    k_next       = '0;
                    kk_next      = '0;
                    g_next       = '0;
                    state_next   = ST_RUN;
                end
                else if (w_reg == 2'd2)
                    state_next = ST_FINISH;
                else
                    w_next = w_reg + 2'd1;
            end
            ST_RUN:
            begin
                // advance the cosine angle; short windows restart it per group
                if (is_short && (kk_reg == 3'd5))
                    m_next = m_start_reg;
                else
                    m_next = m_adv;
                if (kk_reg == 3'd5)
                begin
                    kk_next = '0;
                    g_next  = g_reg + 2'd1;
                end
                else
                    kk_next = kk_reg + 3'd1;
                if (k_reg == 5'd17)
                begin
                    k_next     = '0;
                    state_next = ST_DRAIN;
                end
                else
                    k_next = k_reg + 5'd1;
            end
            ST_DRAIN:
            begin
                // wait out the multiplier and accumulator stages
                if (k_reg == 5'd1)
                    state_next = ST_WIN;
                else
                    k_next = k_reg + 5'd1;
            end
            ST_WIN:
            begin
                win_prod_next = acc_sat * win_reg;
                state_next    = ST_PIECE;
            end
            ST_PIECE:
            begin
                frame_next = frame_reg + round_q30(win_prod_reg);
                if (!is_short || (w_reg == 2'd2))
                    state_next = ST_FINISH;
                else
                begin
                    w_next     = w_reg + 2'd1;
                    state_next = ST_SETUP;
                end
            end
            ST_FINISH:
            begin
                if (j_reg < 6'd18)
                begin
                    if (out_free)
                    begin
                        out_valid_next  = 1'b1;
                        out_sample_next = sample_val;
                        out_index_next  = idx18;
                        out_last_next   = (j_reg == 6'd17);
                        j_next          = j_reg + 6'd1;
                        w_next          = '0;
                        frame_next      = '0;
                        state_next      = ST_SETUP;
                    end
                end
                else if (j_reg == 6'd35)
                    state_next = ST_IDLE;
                else
                begin
                    j_next     = j_reg + 6'd1;
                    w_next     = '0;
                    frame_next = '0;
                    state_next = ST_SETUP;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            j_reg         <= '0;
            w_reg         <= '0;
            k_reg         <= '0;
            kk_reg        <= '0;
            g_reg         <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            j_reg         <= j_next;
            w_reg         <= w_next;
            k_reg         <= k_next;
            kk_reg        <= kk_next;
            g_reg         <= g_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        m_reg          <= m_next;
        m_start_reg    <= m_start_next;
        m_step_reg     <= m_step_next;
        win_reg        <= win_next;
        bt_reg         <= bt_next;
        row_reg        <= row_next;
        win_prod_reg   <= win_prod_next;
        frame_reg      <= frame_next;
        out_sample_reg <= out_sample_next;
        out_index_reg  <= out_index_next;
        out_last_reg   <= out_last_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {3'b000, out_index_reg, out_sample_reg};
    assign m_axis_tlast  = out_last_reg;

endmodule

`default_nettype wire

// File: design/mp3_wola_checker.sv
// Port-level checker for the IMDCT block, bound to the top level.
`default_nettype none

module mp3_wola_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic [39:0] s_axis_tdata,
    input logic [7:0]  s_axis_tuser,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [39:0] m_axis_tdata,
    input logic        m_axis_tlast
);

    a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && !s_axis_tready |=>
            s_axis_tvalid && $stable(s_axis_tdata) && $stable(s_axis_tuser))
        else $error("input item changed while waiting");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
        else $error("output item changed while stalled");

    a_last_index: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (m_axis_tlast == (m_axis_tdata[36:32] == 5'd17)))
        else $error("tlast does not match sample index 17");

    a_index_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (m_axis_tdata[36:32] <= 5'd17) && (m_axis_tdata[39:37] == 3'd0))
        else $error("sample index out of range or fill bits set");

    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && (m_axis_tdata[36:32] != 5'd17) |-> !s_axis_tready)
        else $error("input taken while a transform is still emitting");

endmodule

bind mp3_imdct_window_overlap_add mp3_wola_checker u_checker (.*);

`default_nettype wire
